// ----- rtl/shfr_pkg.sv -----
// Package for the sync-header frame receiver: sizes, status codes, FSM states
// and the structs passed between the front, the command queue and the back end.
// No dependencies.
package shfr_pkg;

    localparam int FRAME_BYTES  = 50;
    localparam int PAYLOAD_MAX  = FRAME_BYTES - 4;
    localparam int SYNC_LEN     = 4;
    localparam int SYNC_CNT_W   = $clog2(SYNC_LEN);
    localparam int POS_W        = $clog2(PAYLOAD_MAX + 1);
    localparam int RAM_AW       = $clog2(PAYLOAD_MAX);
    localparam int BYTE_INDEX_W = 6;
    localparam int CMD_DEPTH    = 2;
    localparam int OUT_DEPTH    = 2;
    localparam int ADDR_W       = 3;
    localparam int REG_SYNC_BYTE = 0;
    localparam logic [7:0] SYNC_RESET = 8'hFC;

    typedef enum logic [1:0] {
        ST_PAYLOAD = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_BAD_SUM = 2'd2,
        ST_BAD_LEN = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        FS_HUNT,
        FS_KIND,
        FS_LEN,
        FS_BODY,
        FS_CHK_HI
    } t_front_state;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_SINGLE,
        BS_DRAIN
    } t_back_state;

    typedef struct packed {
        t_status    status;
        logic [7:0] kind;
        logic [7:0] length;
    } t_cmd;

    typedef struct packed {
        logic              we;
        logic [RAM_AW-1:0] addr;
        logic [7:0]        data;
    } t_ram_wr;

    typedef struct packed {
        t_status                  status;
        logic [7:0]               data;
        logic [7:0]               kind;
        logic [7:0]               length;
        logic [BYTE_INDEX_W-1:0]  index;
        logic                     last;
    } t_result;

endpackage

// ----- rtl/shfr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module shfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 46
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/shfr_front.sv -----
// Front end: hunts for the sync header, parses type and length, stores the
// payload, sums it and checks the checksum. Issues one command per frame end.
// Depends on shfr_pkg.
module shfr_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_sync_byte,
    input  logic             i_push,
    input  logic [7:0]       i_rx_byte,
    output logic             o_full,
    input  logic             i_cmd_full,
    input  logic             i_drain_busy,
    output logic             o_cmd_push,
    output shfr_pkg::t_cmd   o_cmd,
    output shfr_pkg::t_ram_wr o_ram_wr
);

    shfr_pkg::t_front_state            r_state, n_state;
    logic [shfr_pkg::SYNC_CNT_W-1:0]   r_sync_cnt;
    logic [shfr_pkg::POS_W-1:0]        r_pos;
    logic [7:0]                        r_kind;
    logic [7:0]                        r_length;
    logic [15:0]                       r_sum;
    logic [7:0]                        r_check_low;

    logic w_take_payload;
    logic w_accept;
    logic w_sync_hit;
    logic w_len_bad;

    assign w_take_payload = (r_state == shfr_pkg::FS_BODY) && (8'(r_pos) < r_length);
    assign o_full         = i_cmd_full || (w_take_payload && i_drain_busy);
    assign w_accept       = i_push && !o_full;
    assign w_sync_hit     = (i_rx_byte == i_sync_byte);
    assign w_len_bad      = (i_rx_byte > 8'(shfr_pkg::PAYLOAD_MAX));

    always_comb begin
        n_state = r_state;
        case (r_state)
            shfr_pkg::FS_HUNT: begin
                if (w_accept && w_sync_hit &&
                    r_sync_cnt == shfr_pkg::SYNC_CNT_W'(shfr_pkg::SYNC_LEN - 1)) begin
                    n_state = shfr_pkg::FS_KIND;
                end
            end
            shfr_pkg::FS_KIND: begin
                if (w_accept) begin
                    n_state = shfr_pkg::FS_LEN;
                end
            end
            shfr_pkg::FS_LEN: begin
                if (w_accept) begin
                    n_state = w_len_bad ? shfr_pkg::FS_HUNT : shfr_pkg::FS_BODY;
                end
            end
            shfr_pkg::FS_BODY: begin
                if (w_accept && !w_take_payload) begin
                    n_state = shfr_pkg::FS_CHK_HI;
                end
            end
            shfr_pkg::FS_CHK_HI: begin
                if (w_accept) begin
                    n_state = shfr_pkg::FS_HUNT;
                end
            end
            default: begin
                n_state = shfr_pkg::FS_HUNT;
            end
        endcase
    end

    always_comb begin
        o_cmd_push    = 1'b0;
        o_cmd.status  = shfr_pkg::ST_PAYLOAD;
        o_cmd.kind    = r_kind;
        o_cmd.length  = r_length;
        o_ram_wr.we   = 1'b0;
        o_ram_wr.addr = r_pos[shfr_pkg::RAM_AW-1:0];
        o_ram_wr.data = i_rx_byte;
        case (r_state)
            shfr_pkg::FS_LEN: begin
                o_cmd_push   = w_accept && w_len_bad;
                o_cmd.status = shfr_pkg::ST_BAD_LEN;
                o_cmd.length = i_rx_byte;
            end
            shfr_pkg::FS_BODY: begin
                o_ram_wr.we = w_accept && w_take_payload;
            end
            shfr_pkg::FS_CHK_HI: begin
                o_cmd_push = w_accept;
                if ({i_rx_byte, r_check_low} != r_sum) begin
                    o_cmd.status = shfr_pkg::ST_BAD_SUM;
                end else if (r_length == 8'd0) begin
                    o_cmd.status = shfr_pkg::ST_EMPTY;
                end else begin
                    o_cmd.status = shfr_pkg::ST_PAYLOAD;
                end
            end
            default: begin
                o_cmd_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= shfr_pkg::FS_HUNT;
            r_sync_cnt  <= '0;
            r_pos       <= '0;
            r_kind      <= '0;
            r_length    <= '0;
            r_sum       <= '0;
            r_check_low <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                case (r_state)
                    shfr_pkg::FS_HUNT: begin
                        r_sync_cnt <= w_sync_hit ? r_sync_cnt + 1'b1 : '0;
                    end
                    shfr_pkg::FS_KIND: begin
                        r_kind <= i_rx_byte;
                    end
                    shfr_pkg::FS_LEN: begin
                        r_length <= i_rx_byte;
                        r_pos    <= '0;
                        r_sum    <= '0;
                    end
                    shfr_pkg::FS_BODY: begin
                        if (w_take_payload) begin
                            r_pos <= r_pos + 1'b1;
                            r_sum <= r_sum + 16'(i_rx_byte);
                        end else begin
                            r_check_low <= i_rx_byte;
                        end
                    end
                    shfr_pkg::FS_CHK_HI: begin
                        r_pos       <= '0;
                        r_sum       <= '0;
                        r_check_low <= '0;
                    end
                    default: begin
                        r_sync_cnt <= '0;
                    end
                endcase
            end
        end
    end

endmodule

// ----- rtl/shfr_cmd_queue.sv -----
// Short command queue between the front end and the back end.
// Depends on shfr_pkg.
module shfr_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  shfr_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output shfr_pkg::t_cmd o_cmd,
    output logic           o_empty
);

    localparam int PTR_W = (shfr_pkg::CMD_DEPTH > 1) ? $clog2(shfr_pkg::CMD_DEPTH) : 1;
    localparam int CNT_W = $clog2(shfr_pkg::CMD_DEPTH + 1);

    shfr_pkg::t_cmd   r_mem [shfr_pkg::CMD_DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_count == CNT_W'(shfr_pkg::CMD_DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_cmd     = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) begin
                r_wptr <= (r_wptr == PTR_W'(shfr_pkg::CMD_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(shfr_pkg::CMD_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/shfr_back.sv -----
// Back end: takes frame commands, drains stored payload bytes from the RAM or
// emits a single status result, through a small output queue.
// Depends on shfr_pkg.
module shfr_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_empty,
    input  shfr_pkg::t_cmd            i_cmd,
    output logic                      o_cmd_pop,
    output logic                      o_busy,
    output logic                      o_ram_re,
    output logic [shfr_pkg::RAM_AW-1:0] o_ram_raddr,
    input  logic [7:0]                i_ram_rdata,
    output logic                      o_empty,
    input  logic                      i_pop,
    output shfr_pkg::t_result         o_result
);

    localparam int PTR_W = (shfr_pkg::OUT_DEPTH > 1) ? $clog2(shfr_pkg::OUT_DEPTH) : 1;
    localparam int CNT_W = $clog2(shfr_pkg::OUT_DEPTH + 1);

    shfr_pkg::t_back_state      r_state, n_state;
    shfr_pkg::t_cmd             r_cmd;
    logic [shfr_pkg::POS_W-1:0] r_idx;
    logic                       r_rd_valid;
    shfr_pkg::t_result          r_rd_meta;
    shfr_pkg::t_result          r_out [shfr_pkg::OUT_DEPTH];
    logic [PTR_W-1:0]           r_wptr, r_rptr;
    logic [CNT_W-1:0]           r_count;

    logic              w_room;
    logic              w_is_last;
    logic              w_single_push;
    logic              w_out_push;
    logic              w_out_pop;
    shfr_pkg::t_result w_out_data;
    shfr_pkg::t_result w_single;

    assign w_room    = ({1'b0, r_count} + (CNT_W + 1)'(r_rd_valid)) <
                       (CNT_W + 1)'(shfr_pkg::OUT_DEPTH);
    assign w_is_last = (8'(r_idx) == r_cmd.length - 8'd1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            shfr_pkg::BS_IDLE: begin
                if (!i_cmd_empty) begin
                    n_state = (i_cmd.status == shfr_pkg::ST_PAYLOAD) ?
                              shfr_pkg::BS_DRAIN : shfr_pkg::BS_SINGLE;
                end
            end
            shfr_pkg::BS_SINGLE: begin
                if (w_room && !r_rd_valid) begin
                    n_state = shfr_pkg::BS_IDLE;
                end
            end
            shfr_pkg::BS_DRAIN: begin
                if (w_room && w_is_last) begin
                    n_state = shfr_pkg::BS_IDLE;
                end
            end
            default: begin
                n_state = shfr_pkg::BS_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd_pop     = 1'b0;
        o_ram_re      = 1'b0;
        w_single_push = 1'b0;
        case (r_state)
            shfr_pkg::BS_IDLE:   o_cmd_pop     = !i_cmd_empty;
            shfr_pkg::BS_SINGLE: w_single_push = w_room && !r_rd_valid;
            shfr_pkg::BS_DRAIN:  o_ram_re      = w_room;
            default:             o_cmd_pop     = 1'b0;
        endcase
    end

    assign o_busy      = (r_state != shfr_pkg::BS_IDLE);
    assign o_ram_raddr = r_idx[shfr_pkg::RAM_AW-1:0];

    always_comb begin
        w_single.status = r_cmd.status;
        w_single.data   = '0;
        w_single.kind   = r_cmd.kind;
        w_single.length = r_cmd.length;
        w_single.index  = '0;
        w_single.last   = 1'b1;
        w_out_data      = r_rd_meta;
        if (r_rd_valid) begin
            w_out_data.data = i_ram_rdata;
        end else begin
            w_out_data = w_single;
        end
    end

    assign w_out_push = r_rd_valid || w_single_push;
    assign w_out_pop  = i_pop && !o_empty;
    assign o_empty    = (r_count == '0);
    assign o_result   = r_out[r_rptr];

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        r_rd_meta.status <= shfr_pkg::ST_PAYLOAD;
        r_rd_meta.data   <= '0;
        r_rd_meta.kind   <= r_cmd.kind;
        r_rd_meta.length <= r_cmd.length;
        r_rd_meta.index  <= shfr_pkg::BYTE_INDEX_W'(r_idx);
        r_rd_meta.last   <= w_is_last;
        if (w_out_push) begin
            r_out[r_wptr] <= w_out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= shfr_pkg::BS_IDLE;
            r_idx      <= '0;
            r_rd_valid <= 1'b0;
            r_wptr     <= '0;
            r_rptr     <= '0;
            r_count    <= '0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= o_ram_re;
            if (o_cmd_pop) begin
                r_idx <= '0;
            end else if (o_ram_re) begin
                r_idx <= r_idx + 1'b1;
            end
            if (w_out_push) begin
                r_wptr <= (r_wptr == PTR_W'(shfr_pkg::OUT_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_out_pop) begin
                r_rptr <= (r_rptr == PTR_W'(shfr_pkg::OUT_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({w_out_push, w_out_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/sync_header_frame_receiver.sv -----
// Top level of the sync-header frame receiver: configuration register, front
// end, command queue, payload RAM and back end.
// Depends on shfr_pkg, shfr_front, shfr_cmd_queue, shfr_ram, shfr_back.
//
// Usage:
//   Input: one received byte per transfer on i_rx_byte (push/full). The front
//   takes a byte every cycle full is low, as it hunts, parses, stores payload.
//   Results: a queue interface (empty/pop). A good frame yields its payload
//   bytes in order with o_last on the final one; an empty frame, a checksum
//   mismatch or an oversized length yields one result with o_last set.
//   Path: a status result goes through the command queue and the back end's
//   command register to the output queue; a payload byte also goes through
//   the registered RAM read. Reads overlap while the 2-entry output queue has
//   room. Stall: full rises while a payload byte comes in as the back end is
//   busy or a command waits, or while the 2-entry command queue is full.
//   Results wait in the output queue while pop is low; nothing is dropped.
//   Configuration: sync_byte at byte address 0, written over the APB port by
//   the user only while idle, which the block does not enforce; reads return
//   it. Reset sets it to 0xFC, restarts hunting and empties both queues. The
//   payload RAM is not cleared.
module sync_header_frame_receiver (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [shfr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        push,
    output logic                        full,
    input  logic [7:0]                  i_rx_byte,
    output logic                        empty,
    input  logic                        pop,
    output logic [1:0]                  o_status,
    output logic [7:0]                  o_data,
    output logic [7:0]                  o_frame_kind,
    output logic [7:0]                  o_frame_length,
    output logic [5:0]                  o_byte_index,
    output logic                        o_last
);

    logic [7:0]                  r_sync_byte;
    logic                        w_cfg_wr;
    logic                        w_sel_sync;
    logic                        w_cmd_push, w_cmd_pop, w_cmd_full, w_cmd_empty;
    shfr_pkg::t_cmd              w_cmd_in, w_cmd_out;
    shfr_pkg::t_ram_wr           w_ram_wr;
    logic                        w_ram_re;
    logic [shfr_pkg::RAM_AW-1:0] w_ram_raddr;
    logic [7:0]                  w_ram_rdata;
    logic                        w_back_busy;
    shfr_pkg::t_result           w_result;

    assign pready     = 1'b1;
    assign w_sel_sync = (paddr[shfr_pkg::ADDR_W-1:2] ==
                         (shfr_pkg::ADDR_W - 2)'(shfr_pkg::REG_SYNC_BYTE));
    assign w_cfg_wr   = psel && penable && pwrite && pready && w_sel_sync;
    assign prdata     = w_sel_sync ? {24'd0, r_sync_byte} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_byte <= shfr_pkg::SYNC_RESET;
        end else if (w_cfg_wr) begin
            r_sync_byte <= pwdata[7:0];
        end
    end

    shfr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sync_byte  (r_sync_byte),
        .i_push       (push),
        .i_rx_byte    (i_rx_byte),
        .o_full       (full),
        .i_cmd_full   (w_cmd_full),
        .i_drain_busy (w_back_busy || !w_cmd_empty),
        .o_cmd_push   (w_cmd_push),
        .o_cmd        (w_cmd_in),
        .o_ram_wr     (w_ram_wr)
    );

    shfr_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_cmd_full),
        .i_pop   (w_cmd_pop),
        .o_cmd   (w_cmd_out),
        .o_empty (w_cmd_empty)
    );

    shfr_ram #(
        .WIDTH (8),
        .DEPTH (shfr_pkg::PAYLOAD_MAX)
    ) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_wr.we),
        .i_waddr (w_ram_wr.addr),
        .i_wdata (w_ram_wr.data),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    shfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (w_cmd_empty),
        .i_cmd       (w_cmd_out),
        .o_cmd_pop   (w_cmd_pop),
        .o_busy      (w_back_busy),
        .o_ram_re    (w_ram_re),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (w_result)
    );

    assign o_status       = w_result.status;
    assign o_data         = w_result.data;
    assign o_frame_kind   = w_result.kind;
    assign o_frame_length = w_result.length;
    assign o_byte_index   = w_result.index;
    assign o_last         = w_result.last;

endmodule

// ----- rtl/shfr_checker.sv -----
// Port-level checker for the sync-header frame receiver, bound to the top level.
// Depends on shfr_pkg and sync_header_frame_receiver.
module shfr_port_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        empty,
    input logic                        pop,
    input logic [1:0]                  o_status,
    input logic [7:0]                  o_data,
    input logic [7:0]                  o_frame_kind,
    input logic [7:0]                  o_frame_length,
    input logic [5:0]                  o_byte_index,
    input logic                        o_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_status) && $stable(o_data) &&
                              $stable(o_frame_kind) && $stable(o_frame_length) &&
                              $stable(o_byte_index) && $stable(o_last)))
        else $error("stalled result changed");

    a_status_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != shfr_pkg::ST_PAYLOAD) |->
        (o_last && o_data == 8'd0 && o_byte_index == 6'd0))
        else $error("status result malformed");

    a_len_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == shfr_pkg::ST_BAD_LEN) |->
        (o_frame_length > 8'(shfr_pkg::PAYLOAD_MAX)))
        else $error("length error on a legal length");

    a_payload_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == shfr_pkg::ST_PAYLOAD) |->
        (8'(o_byte_index) < o_frame_length &&
         o_last == (8'(o_byte_index) == o_frame_length - 8'd1)))
        else $error("payload index or last mark wrong");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("results present after reset");

endmodule

bind sync_header_frame_receiver shfr_port_checker u_shfr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .empty          (empty),
    .pop            (pop),
    .o_status       (o_status),
    .o_data         (o_data),
    .o_frame_kind   (o_frame_kind),
    .o_frame_length (o_frame_length),
    .o_byte_index   (o_byte_index),
    .o_last         (o_last)
);

// ----- bench/shfr_checker.sv -----
// Checker for the sync-header frame receiver: tracks the sync byte register,
// predicts the results of every accepted byte and compares each popped result.
// Depends on shfr_pkg.
module shfr_checker
    import shfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [31:0]       i_pwdata,
    input  logic [31:0]       i_prdata,
    input  logic              i_pready,
    input  logic              i_push,
    input  logic              i_full,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_empty,
    input  logic              i_pop,
    input  logic [1:0]        i_status,
    input  logic [7:0]        i_data,
    input  logic [7:0]        i_frame_kind,
    input  logic [7:0]        i_frame_length,
    input  logic [5:0]        i_byte_index,
    input  logic              i_last,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    t_front_state     phase;
    logic [2:0]       hunt_cnt;
    logic [POS_W-1:0] body_pos;
    logic [7:0]       kind_q;
    logic [7:0]       len_q;
    logic [7:0]       chk_lo;
    logic [7:0]       sync_val;
    logic [15:0]      sum_q;
    logic [7:0]       payload_copy [PAYLOAD_MAX];
    t_result          frame_results_q [$];
    t_result          got;
    t_result          want;
    int               fail_count = 0;
    int               checked = 0;

    function automatic t_result make_result(t_status st, logic [7:0] d, logic [5:0] idx,
                                            logic lst);
        t_result r;
        r.status = st;
        r.data   = d;
        r.kind   = kind_q;
        r.length = len_q;
        r.index  = idx;
        r.last   = lst;
        return r;
    endfunction

    task automatic restart_hunt();
        phase    = FS_HUNT;
        hunt_cnt = '0;
        body_pos = '0;
        sum_q    = '0;
        chk_lo   = '0;
    endtask

    task automatic predict_byte(input logic [7:0] b);
        logic [15:0] chk;
        case (phase)
            FS_HUNT: begin
                if (b == sync_val) begin
                    hunt_cnt++;
                    if (hunt_cnt == 3'(SYNC_LEN)) phase = FS_KIND;
                end else begin
                    hunt_cnt = '0;
                end
            end
            FS_KIND: begin
                kind_q = b;
                phase  = FS_LEN;
            end
            FS_LEN: begin
                len_q    = b;
                body_pos = '0;
                sum_q    = '0;
                if (int'(len_q) > PAYLOAD_MAX) begin
                    frame_results_q.push_back(make_result(ST_BAD_LEN, 8'h00, 6'd0, 1'b1));
                    restart_hunt();
                end else begin
                    phase = FS_BODY;
                end
            end
            FS_BODY: begin
                if (int'(body_pos) < int'(len_q)) begin
                    payload_copy[body_pos] = b;
                    sum_q = sum_q + 16'(b);
                    body_pos++;
                end else begin
                    chk_lo = b;
                    phase  = FS_CHK_HI;
                end
            end
            default: begin
                chk = {b, chk_lo};
                if (chk != sum_q) begin
                    frame_results_q.push_back(make_result(ST_BAD_SUM, 8'h00, 6'd0, 1'b1));
                end else if (len_q == 8'd0) begin
                    frame_results_q.push_back(make_result(ST_EMPTY, 8'h00, 6'd0, 1'b1));
                end else begin
                    for (int i = 0; i < int'(len_q); i++) begin
                        frame_results_q.push_back(make_result(ST_PAYLOAD, payload_copy[i],
                                                              6'(i), i == int'(len_q) - 1));
                    end
                end
                restart_hunt();
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sync_val = SYNC_RESET;
            kind_q   = '0;
            len_q    = '0;
            restart_hunt();
            frame_results_q.delete();
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (i_paddr == ADDR_W'(REG_SYNC_BYTE * 4)) sync_val = i_pwdata[7:0];
                end else if (i_prdata != {24'd0, sync_val}) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("[%0t] sync_byte read: expected %08h, got %08h",
                                 $realtime, {24'd0, sync_val}, i_prdata);
                end
            end
            if (i_push && !i_full) predict_byte(i_rx_byte);
            if (i_pop && !i_empty) begin
                got.status = t_status'(i_status);
                got.data   = i_data;
                got.kind   = i_frame_kind;
                got.length = i_frame_length;
                got.index  = i_byte_index;
                got.last   = i_last;
                if (frame_results_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("[%0t] unexpected result: status=%0d data=%02h kind=%02h",
                                 $realtime, got.status, got.data, got.kind);
                end else begin
                    want = frame_results_q.pop_front();
                    checked++;
                    if (got != want) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("[%0t] result %0d mismatch", $realtime, checked);
                            $display("  expected status=%0d data=%02h kind=%02h len=%0d idx=%0d last=%0b",
                                     want.status, want.data, want.kind, want.length,
                                     want.index, want.last);
                            $display("  actual   status=%0d data=%02h kind=%02h len=%0d idx=%0d last=%0b",
                                     got.status, got.data, got.kind, got.length,
                                     got.index, got.last);
                        end
                    end
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= frame_results_q.size();
        o_checked    <= checked;
    end

endmodule

// ----- bench/tb_top.sv -----
// Testbench top for the sync-header frame receiver: clock, reset, APB setup of
// the sync byte, framed byte stimulus with bursts and stalls, and the verdict.
// Depends on shfr_pkg, shfr_checker and sync_header_frame_receiver.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import shfr_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_CYCLES = 16;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              push    = 1'b0;
    logic              full;
    logic [7:0]        rx_byte = '0;
    logic              empty;
    logic              pop     = 1'b0;
    logic [1:0]        o_status;
    logic [7:0]        o_data;
    logic [7:0]        o_frame_kind;
    logic [7:0]        o_frame_length;
    logic [5:0]        o_byte_index;
    logic              o_last;

    int                fail_count;
    int                pending;
    int                checked;
    int                cycle_count = 0;
    int                bytes_sent = 0;
    int                burst_left = 0;
    int                pop_mode = 0;
    int                pop_run = 0;
    int                settings = 1;
    logic [7:0]        cur_sync = SYNC_RESET;

    sync_header_frame_receiver i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .push           (push),
        .full           (full),
        .i_rx_byte      (rx_byte),
        .empty          (empty),
        .pop            (pop),
        .o_status       (o_status),
        .o_data         (o_data),
        .o_frame_kind   (o_frame_kind),
        .o_frame_length (o_frame_length),
        .o_byte_index   (o_byte_index),
        .o_last         (o_last)
    );

    shfr_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_prdata       (prdata),
        .i_pready       (pready),
        .i_push         (push),
        .i_full         (full),
        .i_rx_byte      (rx_byte),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_status       (o_status),
        .i_data         (o_data),
        .i_frame_kind   (o_frame_kind),
        .i_frame_length (o_frame_length),
        .i_byte_index   (o_byte_index),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL sync_header_frame_receiver");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (pop_run == 0) begin
            pop_mode = $urandom_range(0, 2);
            pop_run  = $urandom_range(4, 40);
        end
        pop_run--;
        case (pop_mode)
            0: pop <= 1'b1;
            1: pop <= 1'($urandom_range(0, 1));
            default: pop <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                push    <= 1'b0;
                rx_byte <= 8'($urandom);
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        push    <= 1'b1;
        rx_byte <= b;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] kind, input logic [7:0] len, input bit bad_sum);
        logic [15:0] sum;
        logic [7:0]  b;
        sum = '0;
        repeat (SYNC_LEN) send_byte(cur_sync);
        send_byte(kind);
        send_byte(len);
        if (int'(len) <= PAYLOAD_MAX) begin
            repeat (len) begin
                b = 8'($urandom);
                sum = sum + 16'(b);
                send_byte(b);
            end
            if (bad_sum) sum = sum ^ (16'd1 << $urandom_range(0, 15));
            send_byte(sum[7:0]);
            send_byte(sum[15:8]);
        end
    endtask

    task automatic reg_write(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(REG_SYNC_BYTE * 4);
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic reg_read();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'(REG_SYNC_BYTE * 4);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        int          r;
        int          lr;
        int          phase_start;
        logic [7:0]  len;
        logic [7:0]  nb;
        logic [7:0]  sync_plan [5];

        sync_plan = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom), SYNC_RESET};
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        reg_read();
        send_byte(SYNC_RESET);
        send_byte(8'h00);
        send_frame(8'h00, 8'(PAYLOAD_MAX + 1), 1'b0);
        send_frame(8'hFF, 8'd1, 1'b0);
        send_frame(8'h5A, 8'd0, 1'b1);
        drain_results();

        for (int p = 0; p < 5; p++) begin
            cur_sync = sync_plan[p];
            reg_write({24'($urandom), cur_sync});
            reg_read();
            settings++;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < 48) begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    lr = $urandom_range(0, 19);
                    if (lr == 0) len = 8'd0;
                    else if (lr == 1) len = 8'(PAYLOAD_MAX);
                    else len = 8'($urandom_range(1, 8));
                    send_frame(8'($urandom), len, $urandom_range(0, 4) == 0);
                end else if (r < 78) begin
                    if ($urandom_range(0, 3) == 0) len = 8'hFF;
                    else len = 8'($urandom_range(PAYLOAD_MAX + 1, 255));
                    send_frame(8'($urandom), len, 1'b0);
                end else if (r < 88) begin
                    repeat ($urandom_range(1, 3)) send_byte(cur_sync);
                    send_byte(cur_sync ^ 8'(1 << $urandom_range(0, 7)));
                end else begin
                    repeat ($urandom_range(1, 4)) begin
                        nb = 8'($urandom);
                        if (nb == cur_sync) nb = nb ^ 8'h01;
                        send_byte(nb);
                    end
                end
            end
            // leave the hunt partly matched so the next setting lands mid-hunt
            repeat ($urandom_range(0, 3)) send_byte(cur_sync);
            drain_results();
        end

        $display("Sent %0d bytes under %0d sync byte settings; %0d results checked.",
                 bytes_sent, settings, checked);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS sync_header_frame_receiver");
        end else begin
            $display("FAIL sync_header_frame_receiver");
        end
        $finish;
    end

endmodule
